FILE: sv/s5scan_pkg.sv
// s5scan_pkg: types, constants and helpers shared by the s5 sleep-type scanner
// used by s5scan_parse and acpi_s5_sleep_type_scanner_top, no dependencies
`default_nettype none

package s5scan_pkg;

  localparam int unsigned PACKAGE_WINDOW_DEF = 16;
  localparam int unsigned TAIL_MARGIN_DEF    = 12;
  localparam int unsigned LENGTH_BITS_DEF    = 20;

  localparam int unsigned TABLE_LEN_W = 20;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VALUE_W     = 16;

  localparam logic [31:0] NAME_WORD   = 32'h5F53_355F;
  localparam logic [7:0]  PKG_OP      = 8'h12;
  localparam logic [7:0]  BYTE_PREFIX = 8'h0A;
  localparam logic [7:0]  LEN_MASK    = 8'hC0;
  localparam logic [7:0]  LEN_TWO     = 8'h40;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_LEN0    = 4'd1,
    PH_LEN1    = 4'd2,
    PH_COUNT   = 4'd3,
    PH_A_FIRST = 4'd4,
    PH_A_VALUE = 4'd5,
    PH_B_FIRST = 4'd6,
    PH_B_VALUE = 4'd7,
    PH_DONE    = 4'd8
  } s5scan_phase_e;

  typedef struct packed {
    logic                 produce;
    logic                 found;
    logic [VALUE_W-1:0]   sleep_type_a;
    logic [VALUE_W-1:0]   sleep_type_b;
  } s5scan_res_t;

  // value << 10, kept to 16 bits
  function automatic logic [VALUE_W-1:0] shifted(input logic [BYTE_W-1:0] b);
    shifted = {b[5:0], 10'b0};
  endfunction

endpackage

`default_nettype wire

FILE: sv/s5scan_parse.sv
// s5scan_parse: scan state registers and the per-byte step logic
// depends on s5scan_pkg
`default_nettype none

module s5scan_parse
  import s5scan_pkg::*;
#(
  parameter int unsigned PackageWindow = PACKAGE_WINDOW_DEF,
  parameter int unsigned TailMargin    = TAIL_MARGIN_DEF,
  parameter int unsigned LengthBits    = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [BYTE_W-1:0]     byte_i,
  input  wire logic                  last_i,
  input  wire logic [LengthBits-1:0] table_len_i,
  output s5scan_res_t                res_o
);

  localparam int unsigned WinW = $clog2(PackageWindow + 1);
  localparam int unsigned ExtW = LengthBits + 1;
  localparam logic [LengthBits-1:0] PosMax = {LengthBits{1'b1}};

  s5scan_phase_e          phase_q, phase_d;
  logic [LengthBits-1:0]  pos_q, pos_d;
  logic [23:0]            recent_q, recent_d;
  logic [WinW-1:0]        win_q, win_d;
  logic [VALUE_W-1:0]     first_q, first_d;
  logic                   given_q, given_d;

  logic [31:0]            word;
  logic                   name_hit;
  logic                   counts;
  logic [ExtW-1:0]        tail_end;
  logic                   found_now;

  assign word     = {recent_q, byte_i};
  assign name_hit = (word == NAME_WORD);
  assign tail_end = {1'b0, pos_q} - ExtW'(3) + ExtW'(TailMargin);
  assign counts   = name_hit && (pos_q >= LengthBits'(3)) && (pos_q != PosMax)
                    && (tail_end < {1'b0, table_len_i});

  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    first_d   = first_q;
    given_d   = given_q;
    found_now = 1'b0;
    unique case (phase_q)
      PH_SEARCH: begin
        if ((win_q != '0) && (byte_i == PKG_OP)) begin
          phase_d = PH_LEN0;
          win_d   = '0;
        end else begin
          if (win_q != '0) begin
            win_d = win_q - WinW'(1);
          end
          if (counts) begin
            win_d = WinW'(PackageWindow);
          end
        end
      end
      PH_LEN0: begin
        phase_d = ((byte_i & LEN_MASK) == LEN_TWO) ? PH_LEN1 : PH_COUNT;
      end
      PH_LEN1:  phase_d = PH_COUNT;
      PH_COUNT: phase_d = PH_A_FIRST;
      PH_A_FIRST: begin
        if (byte_i == BYTE_PREFIX) begin
          phase_d = PH_A_VALUE;
        end else begin
          first_d = shifted(byte_i);
          phase_d = PH_B_FIRST;
        end
      end
      PH_A_VALUE: begin
        first_d = shifted(byte_i);
        phase_d = PH_B_FIRST;
      end
      PH_B_FIRST: begin
        if (byte_i == BYTE_PREFIX) begin
          phase_d = PH_B_VALUE;
        end else begin
          found_now = 1'b1;
          given_d   = 1'b1;
          phase_d   = PH_DONE;
        end
      end
      PH_B_VALUE: begin
        found_now = 1'b1;
        given_d   = 1'b1;
        phase_d   = PH_DONE;
      end
      default: phase_d = PH_DONE;
    endcase

    recent_d = {recent_q[15:0], byte_i};
    pos_d    = (pos_q == PosMax) ? pos_q : pos_q + LengthBits'(1);

    if (last_i) begin
      phase_d  = PH_SEARCH;
      pos_d    = '0;
      recent_d = '0;
      win_d    = '0;
      first_d  = '0;
      given_d  = 1'b0;
    end
  end

  always_comb begin
    res_o.produce      = found_now || (last_i && !given_q);
    res_o.found        = found_now;
    res_o.sleep_type_a = found_now ? first_q : '0;
    res_o.sleep_type_b = found_now ? shifted(byte_i) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      pos_q    <= '0;
      recent_q <= '0;
      win_q    <= '0;
      first_q  <= '0;
      given_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      recent_q <= recent_d;
      win_q    <= win_d;
      first_q  <= first_d;
      given_q  <= given_d;
    end
  end

  a_win_only_searching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != '0) |-> (phase_q == PH_SEARCH))
    else $error("package window open outside search");

  a_given_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> (phase_q == PH_DONE))
    else $error("result flag set outside done phase");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (pos_q == '0 && phase_q == PH_SEARCH && !given_q))
    else $error("scan state not cleared after last byte");

  a_found_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.found |-> (phase_q == PH_B_FIRST || phase_q == PH_B_VALUE))
    else $error("found outside value phase");

endmodule

`default_nettype wire

FILE: sv/acpi_s5_sleep_type_scanner_top.sv
// acpi_s5_sleep_type_scanner_top: input register, scan step, result register
// depends on s5scan_pkg and s5scan_parse
//
//   channel   direction  payload
//   s_axis    in         tdata[7:0] data_byte, tlast last
//   m_axis    out        tdata[15:0] sleep_type_a, [31:16] sleep_type_b, tuser[0] found
//   cfg       in         data[19:0] table_length
//
// one byte per cycle while m_axis does not stall: a byte waits in the input register,
// its step updates the scan state and loads any result in the same cycle
// m_axis_tvalid rises only after the byte has passed the input register and then
// the result register, so the result transfer follows both
// reset clears all scan state and table_length to zero
// a stalled m_axis holds only a byte that produces a result, other bytes flow
`default_nettype none

module acpi_s5_sleep_type_scanner_top
  import s5scan_pkg::*;
#(
  parameter int unsigned PackageWindow = PACKAGE_WINDOW_DEF,
  parameter int unsigned TailMargin    = TAIL_MARGIN_DEF,
  parameter int unsigned LengthBits    = LENGTH_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [7:0]             s_axis_tdata_i,   // data_byte
  input  wire logic                   s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [31:0]                 m_axis_tdata_o,   // sleep_type_a, sleep_type_b
  output logic [0:0]                  m_axis_tuser_o,   // found
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [TABLE_LEN_W-1:0] cfg_data_i        // table_length
);

  logic                  in_valid_q;
  logic [BYTE_W-1:0]     in_byte_q;
  logic                  in_last_q;
  logic [LengthBits-1:0] table_len_q;
  logic                  out_valid_q;
  s5scan_res_t           out_q;
  s5scan_res_t           res;
  logic                  out_free;
  logic                  advance;

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!res.produce || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  s5scan_parse #(
    .PackageWindow (PackageWindow),
    .TailMargin    (TailMargin),
    .LengthBits    (LengthBits)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .table_len_i (table_len_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      table_len_q <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && res.produce) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        table_len_q <= LengthBits'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && res.produce) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.sleep_type_b, out_q.sleep_type_a};
  assign m_axis_tuser_o  = out_q.found;

endmodule

`default_nettype wire
